// ===== rtl/sipkh_pkg.sv =====
package sipkh_pkg;

    localparam logic [63:0] GOLDEN_K1 = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SIP_C0    = 64'h736f_6d65_7073_6575;
    localparam logic [63:0] SIP_C1    = 64'h646f_7261_6e64_6f6d;
    localparam logic [63:0] SIP_C2    = 64'h6c79_6765_6e65_7261;
    localparam logic [63:0] SIP_C3    = 64'h7465_6462_7974_6573;
    localparam logic [63:0] FINAL_XOR = 64'h0000_0000_0000_00FF;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned BYTES    = WORD_W / 8;
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BYTES);

    // Rounds per absorbed word and in finalisation, counted from zero
    localparam logic [1:0] LAST_ABSORB_RND = 2'd1;
    localparam logic [1:0] LAST_FINAL_RND  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ABSORB,
        S_FINAL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } t_lanes;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                                input int unsigned r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    // One full SipRound
    function automatic t_lanes lane_round(input t_lanes s);
        t_lanes t;
        t   = s;
        t.a = t.a + t.b;
        t.c = t.c + t.d;
        t.b = rotl(t.b, 13) ^ t.a;
        t.d = rotl(t.d, 16) ^ t.c;
        t.a = rotl(t.a, 32);
        t.c = t.c + t.b;
        t.a = t.a + t.d;
        t.b = rotl(t.b, 17) ^ t.c;
        t.d = rotl(t.d, 21) ^ t.a;
        t.c = rotl(t.c, 32);
        return t;
    endfunction

endpackage

// ===== rtl/siphash24_seeded_key_hash.sv =====
// SipHash-2-4 key hasher, one SipRound per clock in the absorb and final states, from a
// single shared round unit. Non-last word: accepted in idle, then its absorb rounds; the next
// word is taken once the block is back in idle. Last word: absorb and finalisation rounds,
//   then the hash is registered in the output state once the output is free; a last word
//   of 8 bytes also absorbs an empty tail block. A new key word waits until the hash is loaded.
// Reset (synchronous, active low): seed zero, state idle, no key open, no result pending.
module siphash24_seeded_key_hash (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: the seed
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sipkh_pkg::WORD_W-1:0]   i_hash_seed,
    // key words in
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sipkh_pkg::WORD_W-1:0]   i_key_word,
    input  logic [sipkh_pkg::COUNT_W-1:0]  i_byte_count,
    input  logic                           i_last_word,
    // hash out
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sipkh_pkg::WORD_W-1:0]   o_hash_value
);
    import sipkh_pkg::*;

    // Control state
    t_state             r_state,   n_state;
    logic [1:0]         r_rnd,     n_rnd;
    logic               r_in_msg,  n_in_msg;
    logic               r_tail,    n_tail;     // empty tail block still to absorb
    logic               r_last,    n_last;     // current key ends with this word
    logic [LEN_W-1:0]   r_len,     n_len;
    logic               r_out_vld, n_out_vld;
    logic [WORD_W-1:0]  r_seed;

    // Datapath
    t_lanes             r_lanes,   n_lanes;
    logic [WORD_W-1:0]  r_msg,     n_msg;      // block being absorbed
    logic [WORD_W-1:0]  r_tail_w,  n_tail_w;   // tail block for a full last word
    logic [WORD_W-1:0]  r_hash,    n_hash;

    // Accept-cycle helpers
    t_lanes             w_start;
    t_lanes             w_round;
    logic [LEN_W-1:0]   w_len_base;
    logic [COUNT_W-1:0] w_count;
    logic               w_full;
    logic [WORD_W-1:0]  w_masked;
    logic               w_in_beat;
    logic               w_out_free;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_hash_value = r_hash;

    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_vld || i_out_ready;

    // The single round unit, shared by absorption and finalisation
    assign w_round = lane_round(r_lanes);

    // Clamp counts above eight; non-last words are always full blocks
    assign w_count = (!i_last_word || i_byte_count > FULL_COUNT) ? FULL_COUNT : i_byte_count;
    assign w_full  = (w_count == FULL_COUNT);
    assign w_len_base = r_in_msg ? r_len : '0;

    // Start of key: seed the lanes, k1 = seed ^ golden ratio; later words keep the running lanes
    always_comb begin
        if (r_in_msg) begin
            w_start = r_lanes;
        end else begin
            w_start.a = SIP_C0 ^ r_seed;
            w_start.b = SIP_C1 ^ r_seed ^ GOLDEN_K1;
            w_start.c = SIP_C2 ^ r_seed;
            w_start.d = SIP_C3 ^ r_seed ^ GOLDEN_K1;
        end
    end

    // Drop bytes at or above the count
    always_comb begin
        w_masked = '0;
        for (int j = 0; j < BYTES; j++) begin
            if (COUNT_W'(j) < w_count) begin
                w_masked[j*8 +: 8] = i_key_word[j*8 +: 8];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_rnd     = r_rnd;
        n_in_msg  = r_in_msg;
        n_tail    = r_tail;
        n_last    = r_last;
        n_len     = r_len;
        n_out_vld = r_out_vld;
        n_lanes   = r_lanes;
        n_msg     = r_msg;
        n_tail_w  = r_tail_w;
        n_hash    = r_hash;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_in_msg = 1'b1;
                    n_last   = i_last_word;
                    n_rnd    = '0;
                    n_state  = S_ABSORB;
                    n_lanes  = w_start;
                    if (w_full) begin
                        // Full block; a full last word still owes a length-only tail
                        n_len    = w_len_base + LEN_W'(BYTES);
                        n_msg    = i_key_word;
                        n_tail   = i_last_word;
                        n_tail_w = {n_len, {(WORD_W-LEN_W){1'b0}}};
                    end else begin
                        n_len    = w_len_base + LEN_W'(w_count);
                        n_msg    = w_masked | {n_len, {(WORD_W-LEN_W){1'b0}}};
                        n_tail   = 1'b0;
                    end
                    n_lanes.d = w_start.d ^ n_msg;
                end
            end
            S_ABSORB: begin
                n_lanes = w_round;
                n_rnd   = r_rnd + 2'd1;
                if (r_rnd == LAST_ABSORB_RND) begin
                    n_lanes.a = w_round.a ^ r_msg;
                    n_rnd     = '0;
                    if (r_tail) begin
                        // Chain straight into the tail block
                        n_tail    = 1'b0;
                        n_msg     = r_tail_w;
                        n_lanes.d = w_round.d ^ r_tail_w;
                    end else if (r_last) begin
                        n_lanes.c = w_round.c ^ FINAL_XOR;
                        n_state   = S_FINAL;
                    end else begin
                        n_state   = S_IDLE;
                    end
                end
            end
            S_FINAL: begin
                n_lanes = w_round;
                n_rnd   = r_rnd + 2'd1;
                if (r_rnd == LAST_FINAL_RND) begin
                    n_rnd   = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free
                if (w_out_free) begin
                    n_hash    = r_lanes.a ^ r_lanes.b ^ r_lanes.c ^ r_lanes.d;
                    n_out_vld = 1'b1;
                    n_in_msg  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rnd     <= '0;
            r_in_msg  <= 1'b0;
            r_tail    <= 1'b0;
            r_last    <= 1'b0;
            r_len     <= '0;
            r_out_vld <= 1'b0;
            r_seed    <= '0;
        end else begin
            r_state   <= n_state;
            r_rnd     <= n_rnd;
            r_in_msg  <= n_in_msg;
            r_tail    <= n_tail;
            r_last    <= n_last;
            r_len     <= n_len;
            r_out_vld <= n_out_vld;
            // Seed is sampled on every accepted configuration beat; it is used only when a key starts
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_hash_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes  <= n_lanes;
        r_msg    <= n_msg;
        r_tail_w <= n_tail_w;
        r_hash   <= n_hash;
    end

endmodule

// ===== rtl/sipkh_checker.sv =====
module sipkh_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [sipkh_pkg::WORD_W-1:0]   i_hash_seed,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic [sipkh_pkg::WORD_W-1:0]   i_key_word,
    input  logic [sipkh_pkg::COUNT_W-1:0]  i_byte_count,
    input  logic                           i_last_word,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [sipkh_pkg::WORD_W-1:0]   o_hash_value
);
    import sipkh_pkg::*;

    logic w_in_beat;
    assign w_in_beat = i_in_valid && o_in_ready;

    // Reset drops any pending result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result still valid after reset");

    // A non-last word holds the input off for its absorb rounds
    a_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && !i_last_word) |=> !o_in_ready ##1 !o_in_ready)
        else $error("input ready during block rounds");

    // A last word holds the input off through its absorb and finalisation rounds
    a_last_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && i_last_word) |=> !o_in_ready ##1 !o_in_ready ##1 !o_in_ready
            ##1 !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("input ready during finalisation");

    // A new result is only loaded while the input side is busy
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while idle");

    // A stalled hash holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_hash_value)))
        else $error("stalled hash changed");

endmodule

bind siphash24_seeded_key_hash sipkh_checker u_sipkh_checker (.*);
